// ===== hdl/oedm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oedm_pkg
// Shared types and constants of the one-edit-distance matcher.
// ----------------------------------------------------------------------------
package oedm_pkg;

  // default reference store depth
  localparam int unsigned MAX_LEN_DEF = 4096;

  // fixed field widths
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned CNT_W  = 20;

  // request kind carried by each input transfer
  typedef enum logic {
    REQ_REF  = 1'b0,
    REQ_CAND = 1'b1
  } req_type_e;

  // one item held between the address stage and the compare stage
  typedef struct packed {
    logic              is_ref;  // reference character
    logic              last;    // final character of its string
    logic [CHAR_W-1:0] ch;      // character byte
    logic              g_prev;  // position-1 lies inside the reference
    logic              g_here;  // position lies inside the reference
    logic              g_next;  // position+1 lies inside the reference
    logic              len_eq;  // candidate length equals reference length
    logic              len_p1;  // candidate one longer
    logic              len_m1;  // candidate one shorter
    logic              len_ok;  // candidate not over-long
    logic [CNT_W-1:0]  cnt;     // candidate number if this closes a candidate
  } s1_item_t;

endpackage

// ===== hdl/oedm_ref_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oedm_ref_store
// Reference character memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module oedm_ref_store #(
  parameter int unsigned MAX_LEN = oedm_pkg::MAX_LEN_DEF,
  parameter int unsigned AW      = $clog2(MAX_LEN)
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [AW-1:0]             wr_addr_i,
  input  logic [oedm_pkg::CHAR_W-1:0] wr_data_i,
  input  logic                      rd_en_i,
  input  logic [AW-1:0]             rd_addr0_i,
  input  logic [AW-1:0]             rd_addr1_i,
  output logic [oedm_pkg::CHAR_W-1:0] rd_data0_o,
  output logic [oedm_pkg::CHAR_W-1:0] rd_data1_o
);
  import oedm_pkg::*;

  logic [CHAR_W-1:0] mem [MAX_LEN];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read ports, data held while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data0_o <= mem[rd_addr0_i];
      rd_data1_o <= mem[rd_addr1_i];
    end
  end

endmodule

// ===== hdl/one_edit_distance_matcher_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_edit_distance_matcher_unit
// Checks streamed candidate strings against a stored reference string for
// edit distance of at most one.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (in_*): one character per transfer. req_type 0 loads a
//   reference character, 1 streams a candidate character; last_char closes
//   the string. A new reference starts with the first reference character
//   after a completed one.
// - Output channel (out_*): one transfer per candidate, on its last
//   character: the verdict and the running candidate number.
// - Throughput: one character per cycle while no result is stalled. The
//   address stage issues reads of the reference at the current and next
//   position; the compare stage uses the registered data, and its verdict
//   is registered in the output register.
// - Stall: the result waits in the output register. Characters that give no
//   result keep flowing; a closing character is held only while a result
//   is stalled, and in_stall_o then rises until the output is taken.
// - Reset: reference length and candidate count clear, flags set, at once.
//   The memory needs no clearing; its data is only used below the length.
// ----------------------------------------------------------------------------
module one_edit_distance_matcher_unit #(
  parameter int unsigned MAX_LEN = oedm_pkg::MAX_LEN_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        in_req_type_i,
  input  logic [oedm_pkg::CHAR_W-1:0] in_char_code_i,
  input  logic                        in_last_char_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        out_is_match_o,
  output logic [oedm_pkg::CNT_W-1:0]  out_candidate_number_o
);
  import oedm_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LEN);      // store address
  localparam int unsigned LW = $clog2(MAX_LEN + 1);  // reference length
  localparam int unsigned PW = $clog2(MAX_LEN + 3);  // candidate position
  localparam int unsigned CW = PW + 1;               // compare width
  localparam logic [PW-1:0] POS_MAX = PW'(MAX_LEN + 2);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);
  localparam logic [CW-1:0] LEN_OK  = CW'(MAX_LEN + 1);

  // address stage state
  logic [LW-1:0]    ref_len_q, ref_len_d;
  logic             ref_done_q, ref_done_d;
  logic [PW-1:0]    pos_q, pos_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // compare stage state
  logic             s1_valid_q, s1_valid_d;
  s1_item_t         s1_q, s1_d;
  logic             pe_q, sub_q, ins_q, del_q;
  logic             pe_d, sub_d, ins_d, del_d;
  logic [CHAR_W-1:0] prev_ch_q;

  // output register
  logic             out_valid_q, out_valid_d;
  logic             out_match_q;
  logic [CNT_W-1:0] out_cnt_q;

  // handshake
  logic acc, is_ref, s1_res, s1_adv, out_free;

  // memory interface
  logic              wr_en, rd_en;
  logic [LW-1:0]     base_len;
  logic [CHAR_W-1:0] rd0, rd1;

  // position arithmetic
  logic [CW-1:0] pc, lc, npc;
  logic [PW-1:0] np;

  // compare results
  logic eq_here, eq_prev, eq_next, mism, verdict;

  // ---- handshake ----
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_res     = !s1_q.is_ref && s1_q.last;
  assign s1_adv     = s1_valid_q && (!s1_res || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign acc        = in_valid_i && !in_stall_o;
  assign is_ref     = (req_type_e'(in_req_type_i) == REQ_REF);

  // ---- address stage: reference write, read addresses, length relations ----
  assign base_len = ref_done_q ? '0 : ref_len_q;
  assign wr_en    = acc && is_ref && (base_len < LEN_MAX);
  assign rd_en    = acc && !is_ref;

  assign pc  = CW'(pos_q);
  assign lc  = CW'(ref_len_q);
  assign np  = (pos_q < POS_MAX) ? pos_q + PW'(1) : pos_q;
  assign npc = CW'(np);

  always_comb begin
    s1_d        = s1_q;
    s1_d.is_ref = is_ref;
    s1_d.last   = in_last_char_i;
    s1_d.ch     = in_char_code_i;
    s1_d.g_here = (pc < lc);
    s1_d.g_next = ((pc + CW'(1)) < lc);
    s1_d.g_prev = (pos_q != '0) && ((pc - CW'(1)) < lc);
    s1_d.len_eq = (npc == lc);
    s1_d.len_p1 = (npc == lc + CW'(1));
    s1_d.len_m1 = (ref_len_q != '0) && (npc == lc - CW'(1));
    s1_d.len_ok = (npc <= LEN_OK);
    s1_d.cnt    = cnt_q + CNT_W'(1);
  end

  // next state of the address stage
  always_comb begin
    ref_len_d  = ref_len_q;
    ref_done_d = ref_done_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    if (acc) begin
      if (is_ref) begin
        ref_len_d  = wr_en ? base_len + LW'(1) : base_len;
        ref_done_d = in_last_char_i;
        pos_d      = '0;
        if (in_last_char_i) begin
          cnt_d = '0;
        end
      end else if (in_last_char_i) begin
        pos_d = '0;
        cnt_d = cnt_q + CNT_W'(1);
      end else begin
        pos_d = np;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_len_q  <= '0;
      ref_done_q <= 1'b0;
      pos_q      <= '0;
      cnt_q      <= '0;
    end else begin
      ref_len_q  <= ref_len_d;
      ref_done_q <= ref_done_d;
      pos_q      <= pos_d;
      cnt_q      <= cnt_d;
    end
  end

  // reference memory
  oedm_ref_store #(
    .MAX_LEN (MAX_LEN),
    .AW      (AW)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (base_len[AW-1:0]),
    .wr_data_i  (in_char_code_i),
    .rd_en_i    (rd_en),
    .rd_addr0_i (pos_q[AW-1:0]),
    .rd_addr1_i (np[AW-1:0]),
    .rd_data0_o (rd0),
    .rd_data1_o (rd1)
  );

  // stage register between address and compare
  assign s1_valid_d = acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q <= s1_d;
    end
  end

  // ---- compare stage: path flags ----
  // ref[i-1] is the ref[i] read for the previous candidate character
  assign eq_here = s1_q.g_here && (rd0 == s1_q.ch);
  assign eq_prev = s1_q.g_prev && (prev_ch_q == s1_q.ch);
  assign eq_next = s1_q.g_next && (rd1 == s1_q.ch);
  assign mism    = !eq_here;

  always_comb begin
    pe_d  = pe_q && !mism;
    sub_d = sub_q && !(mism && !pe_q);
    ins_d = ins_q && !(!pe_q && !eq_prev);
    del_d = del_q && !((mism || !pe_q) && !eq_next);
  end

  // verdict on the closing character
  always_comb begin
    verdict = 1'b0;
    if (s1_q.len_ok) begin
      if (s1_q.len_eq) begin
        verdict = sub_d;
      end else if (s1_q.len_p1) begin
        verdict = ins_d;
      end else if (s1_q.len_m1) begin
        verdict = del_d;
      end
    end
  end

  // flags restart on any reference character and after each candidate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pe_q  <= 1'b1;
      sub_q <= 1'b1;
      ins_q <= 1'b1;
      del_q <= 1'b1;
    end else if (s1_adv) begin
      if (s1_q.is_ref || s1_q.last) begin
        pe_q  <= 1'b1;
        sub_q <= 1'b1;
        ins_q <= 1'b1;
        del_q <= 1'b1;
      end else begin
        pe_q  <= pe_d;
        sub_q <= sub_d;
        ins_q <= ins_d;
        del_q <= del_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && !s1_q.is_ref) begin
      prev_ch_q <= rd0;
    end
  end

  // ---- output register ----
  assign out_valid_d = (s1_adv && s1_res) ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_res) begin
      out_match_q <= verdict;
      out_cnt_q   <= s1_q.cnt;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_is_match_o         = out_match_q;
  assign out_candidate_number_o = out_cnt_q;

endmodule

// ===== hdl/oedm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oedm_checker
// Port-level checks of the matcher, attached to the top level by bind.
// ----------------------------------------------------------------------------
module oedm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        in_req_type_i,
  input logic [oedm_pkg::CHAR_W-1:0] in_char_code_i,
  input logic                        in_last_char_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        out_is_match_o,
  input logic [oedm_pkg::CNT_W-1:0]  out_candidate_number_o
);
  import oedm_pkg::*;

  // a stalled result stays and holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_is_match_o) && $stable(out_candidate_number_o)))
    else $error("stalled result changed");

  // a stalled input character stays and holds its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=>
      (in_valid_i && $stable(in_req_type_i) && $stable(in_char_code_i) &&
       $stable(in_last_char_i)))
    else $error("stalled input character changed");

  // input is only held back by a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // a fresh result comes from a closing candidate character that was taken
  // and passed through the stage register and the output register
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && !in_stall_o && in_last_char_i &&
            (req_type_e'(in_req_type_i) == REQ_CAND), 2))
    else $error("result without a closing candidate character");

endmodule

bind one_edit_distance_matcher_unit oedm_checker u_oedm_checker (.*);

// ===== sim/tb_one_edit_distance_matcher_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_one_edit_distance_matcher_unit
// Self-checking bench for the one-edit-distance matcher. A queue of pending
// characters feeds a clocked driver with random gaps. Each accepted transfer
// updates a local model of the reference store and the path flags, which
// queues the expected verdicts. A clocked monitor takes results under random
// stall, with one long hold-off, and checks each against the oldest verdict.
// ----------------------------------------------------------------------------
module tb_one_edit_distance_matcher_unit;

  import oedm_pkg::*;

  localparam int unsigned TB_MAX_LEN   = MAX_LEN_DEF;
  localparam int          RAND_ITEMS   = 2000;
  localparam int          HOLD_AT      = 400;  // transfers before the long hold-off
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 16;

  typedef enum int {GAP_NONE, GAP_RAND} gap_mode_e;

  typedef enum int {
    EDIT_NONE, EDIT_SUB, EDIT_INS, EDIT_DEL, EDIT_TWO_SUB, EDIT_SWAP, EDIT_RANDOM
  } edit_kind_e;

  typedef struct {
    req_type_e         req;
    logic [CHAR_W-1:0] ch;
    logic              last;
    int                gap;   // idle cycles after this transfer
  } char_item_t;

  typedef struct {
    logic             is_match;
    logic [CNT_W-1:0] number;
  } verdict_t;

  typedef logic [CHAR_W-1:0] str_q_t [$];

  // DUT ports
  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_stall_o;
  logic              in_req_type  = 1'b0;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic              in_last_char = 1'b0;
  logic              out_valid_o;
  logic              out_stall    = 1'b0;
  logic              out_is_match_o;
  logic [CNT_W-1:0]  out_candidate_number_o;

  // stimulus and scoreboard
  char_item_t pending_chars [$];
  verdict_t   verdict_q [$];
  int         pushed_cnt   = 0;
  int         accepted_cnt = 0;
  int         err_cnt      = 0;
  int         idle_left    = 0;
  int         stall_left   = 0;
  logic       rand_stall   = 1'b0;
  int         hold_left    = 0;
  logic       hold_done    = 1'b0;

  // matcher model state
  logic [CHAR_W-1:0] ref_mem [TB_MAX_LEN];
  int unsigned       ref_len  = 0;
  int unsigned       cand_pos = 0;
  logic              ref_done = 1'b0;
  logic              pre_eq   = 1'b1;
  logic              sub_ok   = 1'b1;
  logic              ins_ok   = 1'b1;
  logic              del_ok   = 1'b1;
  logic [CNT_W-1:0]  cand_cnt = '0;

  one_edit_distance_matcher_unit #(
    .MAX_LEN(TB_MAX_LEN)
  ) DUT (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall_o),
    .in_req_type_i         (in_req_type),
    .in_char_code_i        (in_char_code),
    .in_last_char_i        (in_last_char),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall),
    .out_is_match_o        (out_is_match_o),
    .out_candidate_number_o(out_candidate_number_o)
  );

  // clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // reset at the start of the run only
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b0 ^ 1'b1;
  end

  // hang guard
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // model helpers
  // ---------------------------------------------------------------------------

  // reference position exists and holds the character
  function automatic logic ref_has(int unsigned idx, logic [CHAR_W-1:0] ch);
    if (idx >= ref_len || idx >= TB_MAX_LEN) return 1'b0;
    return ref_mem[idx] == ch;
  endfunction

  function automatic void clear_paths();
    cand_pos = 0;
    pre_eq   = 1'b1;
    sub_ok   = 1'b1;
    ins_ok   = 1'b1;
    del_ok   = 1'b1;
  endfunction

  // advance the model by one accepted character; queue a verdict on a
  // candidate's closing character
  task automatic predict_verdict(logic req, logic [CHAR_W-1:0] ch, logic last);
    logic        hit;
    int unsigned i;
    verdict_t    v;
    if (req == REQ_REF) begin
      // first reference character after a completed one starts afresh
      if (ref_done) begin
        ref_len  = 0;
        ref_done = 1'b0;
      end
      // characters past the store are dropped
      if (ref_len < TB_MAX_LEN) begin
        ref_mem[ref_len] = ch;
        ref_len++;
      end
      clear_paths();
      if (last) begin
        ref_done = 1'b1;
        cand_cnt = '0;
      end
    end else begin
      i   = cand_pos;
      hit = ref_has(i, ch);
      if (!hit && !pre_eq) sub_ok = 1'b0;
      if (!pre_eq && (i == 0 || !ref_has(i - 1, ch))) ins_ok = 1'b0;
      if ((!hit || !pre_eq) && !ref_has(i + 1, ch)) del_ok = 1'b0;
      if (!hit) pre_eq = 1'b0;
      if (cand_pos < TB_MAX_LEN + 2) cand_pos++;
      if (last) begin
        v.is_match = 1'b0;
        if (cand_pos <= TB_MAX_LEN + 1) begin
          if (cand_pos == ref_len)
            v.is_match = sub_ok;
          else if (cand_pos == ref_len + 1)
            v.is_match = ins_ok;
          else if (ref_len >= 1 && cand_pos == ref_len - 1)
            v.is_match = del_ok;
        end
        cand_cnt++;
        v.number = cand_cnt;
        verdict_q.insert(verdict_q.size(), v);
        clear_paths();
      end
    end
  endtask

  function automatic void note_error(string msg);
    if (err_cnt < 10) $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap(gap_mode_e mode);
    int r;
    if (mode == GAP_NONE) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // a two-letter alphabet makes neighbouring positions coincide often
  function automatic logic [CHAR_W-1:0] rand_char(logic narrow);
    if (narrow) return ($urandom_range(0, 1) != 0) ? 8'h61 : 8'h62;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_item(req_type_e kind, logic [CHAR_W-1:0] ch, logic last,
                           gap_mode_e mode);
    char_item_t it;
    it.req  = kind;
    it.ch   = ch;
    it.last = last;
    it.gap  = pick_gap(mode);
    pending_chars.insert(pending_chars.size(), it);
    pushed_cnt++;
  endtask

  task automatic push_string(req_type_e kind, str_q_t s, gap_mode_e mode);
    foreach (s[i]) push_item(kind, s[i], i == s.size() - 1, mode);
  endtask

  // derive a candidate from the reference by the given edit
  task automatic build_candidate(input str_q_t r, input edit_kind_e k,
                                 output str_q_t c);
    int p;
    int q;
    logic [CHAR_W-1:0] t;
    c = r;
    case (k)
      EDIT_SUB: begin
        p    = $urandom_range(0, c.size() - 1);
        c[p] = c[p] ^ (8'h01 << $urandom_range(0, 7));
      end
      EDIT_INS: begin
        p = $urandom_range(0, c.size());
        t = ($urandom_range(0, 1) != 0) ? r[$urandom_range(0, r.size() - 1)]
                                         : rand_char(1'b0);
        c.insert(p, t);
      end
      EDIT_DEL: begin
        if (c.size() > 1) c.delete($urandom_range(0, c.size() - 1));
      end
      EDIT_TWO_SUB: begin
        if (c.size() > 1) begin
          p    = $urandom_range(0, c.size() - 2);
          q    = $urandom_range(p + 1, c.size() - 1);
          c[p] = ~c[p];
          c[q] = ~c[q];
        end
      end
      EDIT_SWAP: begin
        if (c.size() > 1) begin
          p        = $urandom_range(0, c.size() - 2);
          t        = c[p];
          c[p]     = c[p + 1];
          c[p + 1] = t;
        end
      end
      EDIT_RANDOM: begin
        c.delete();
        repeat ($urandom_range(1, r.size() + 2))
          c.insert(c.size(), rand_char(1'($urandom_range(0, 1))));
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // driver: one transfer per accepted character, idle gaps from the item
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drv
    char_item_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        predict_verdict(in_req_type, in_char_code, in_last_char);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_valid || !in_stall_o) begin
        if (idle_left != 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (pending_chars.size() != 0) begin
          nxt = pending_chars.pop_front();
          in_req_type  <= nxt.req;
          in_char_code <= nxt.ch;
          in_last_char <= nxt.last;
          in_valid     <= 1'b1;
          idle_left    = nxt.gap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off, so the block backs up and stalls its input
  always @(posedge clk_i) begin
    if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check each result transfer, then pick the next stall level
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : mon
    verdict_t exp_v;
    int       r;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (verdict_q.size() == 0) begin
          note_error($sformatf("unexpected result: match=%0b number=%0d",
                               out_is_match_o, out_candidate_number_o));
        end else begin
          exp_v = verdict_q.pop_front();
          if (out_is_match_o !== exp_v.is_match ||
              out_candidate_number_o !== exp_v.number)
            note_error($sformatf("expected match=%0b number=%0d, got match=%0b number=%0d",
                                 exp_v.is_match, exp_v.number,
                                 out_is_match_o, out_candidate_number_o));
        end
      end
      // runs of ready, short stalls and the odd long stall
      if (stall_left != 0) begin
        stall_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          rand_stall = 1'b0;
          stall_left = $urandom_range(1, 8);
        end else if (r < 95) begin
          rand_stall = 1'b1;
          stall_left = $urandom_range(0, 2);
        end else begin
          rand_stall = 1'b1;
          stall_left = $urandom_range(10, 30);
        end
      end
      out_stall <= rand_stall || (hold_left != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stim
    str_q_t     r;
    str_q_t     c;
    gap_mode_e  mode;
    logic       narrow;
    int         rand_goal;

    // empty reference: a single character counts as one insertion
    c = '{8'h41};
    push_string(REQ_CAND, c, GAP_RAND);
    c = '{8'h41, 8'h42};
    push_string(REQ_CAND, c, GAP_RAND);

    // field extremes in the reference
    r = '{8'h00, 8'hFF, 8'h41};
    push_string(REQ_REF, r, GAP_NONE);
    push_string(REQ_CAND, r, GAP_RAND);          // equal
    c = '{8'h00, 8'h80, 8'h41};
    push_string(REQ_CAND, c, GAP_RAND);          // substitution
    c = '{8'h00, 8'hFF, 8'h7E, 8'h41};
    push_string(REQ_CAND, c, GAP_NONE);          // insertion
    c = '{8'h00, 8'h41};
    push_string(REQ_CAND, c, GAP_RAND);          // deletion
    c = '{8'h41, 8'hFF, 8'h00};
    push_string(REQ_CAND, c, GAP_RAND);          // two mismatches

    // reference interrupting a candidate: no verdict for the partial one
    push_item(REQ_CAND, 8'h00, 1'b0, GAP_RAND);
    push_item(REQ_CAND, 8'hFF, 1'b0, GAP_NONE);
    push_item(REQ_REF, 8'hFF, 1'b1, GAP_RAND);
    push_item(REQ_CAND, 8'h00, 1'b1, GAP_RAND);

    // random part: mostly a fresh reference followed by edited candidates
    rand_goal = pushed_cnt + RAND_ITEMS;
    while (pushed_cnt < rand_goal) begin
      mode = ($urandom_range(0, 3) == 0) ? GAP_NONE : GAP_RAND;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6))
          push_item(req_type_e'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), mode);
        // close whatever reference the noise left open
        push_item(REQ_REF, rand_char(1'b0), 1'b1, mode);
      end
      narrow = ($urandom_range(0, 1) != 0);
      r.delete();
      repeat ($urandom_range(1, 10)) r.insert(r.size(), rand_char(narrow));
      push_string(REQ_REF, r, mode);
      repeat ($urandom_range(2, 8)) begin
        build_candidate(r, edit_kind_e'($urandom_range(EDIT_NONE, EDIT_RANDOM)), c);
        push_string(REQ_CAND, c, mode);
      end
      // now and then leave a candidate open for the next reference to cut off
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 3)) push_item(REQ_CAND, rand_char(narrow), 1'b0, mode);
    end

    // drain: all characters taken, all verdicts seen, then a short tail
    while (pending_chars.size() != 0 || in_valid) @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
